[hdl/ptd_pkg.sv]
// shared codes, widths and slot entry type for the periodic task dispatcher
package ptd_pkg;

  localparam int unsigned NumSlotsDef = 16;

  localparam int unsigned ModeW     = 2;
  localparam int unsigned SlotInW   = 4;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned CounterW  = 8;

  localparam logic [ModeW-1:0] MODE_REGISTER    = 2'd0;
  localparam logic [ModeW-1:0] MODE_SET_COUNTER = 2'd1;
  localparam logic [ModeW-1:0] MODE_SCAN        = 2'd2;

  // one task table entry, everything but the signal counter
  typedef struct packed {
    logic [TimeW-1:0] interval;
    logic [TimeW-1:0] last_time;
    logic             or_mode;
    logic             has_flag;
  } task_entry_t;

endpackage

[hdl/periodic_task_dispatcher.sv]
// periodic task dispatcher: task table in memory with a scan sequencer
// register and set-counter items are written in the cycle they are accepted; busy stays low
// a scan item keeps busy high while it walks the table: one table read per slot, a wait for
// the last read to return, then the ST_DONE state that emits the final result
// a fired slot shows the cycle after the next fired one is checked; the last as busy drops
// the receiver cannot stall; reset clears slot valid bits and counter valid bits at once
module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [ModeW-1:0]           mode_i,
  input  logic [SlotInW-1:0]         slot_i,
  input  logic [TimeW-1:0]           task_interval_i,
  input  logic                       or_mode_i,
  input  logic                       has_flag_i,
  input  logic signed [CounterW-1:0] flag_value_i,
  input  logic [TimeW-1:0]           now_ms_i,
  output logic                       result_valid_o,
  output logic                       fired_o,
  output logic [SlotInW-1:0]         fired_slot_o,
  output logic                       last_o
);

  // index widths: SlotW addresses the table, CntW can also hold NUM_SLOTS itself
  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CntW  = $clog2(NUM_SLOTS + 1);
  localparam int unsigned CmpW  = 7;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // task table and counter table, one read and one write port each
  task_entry_t                task_mem [NUM_SLOTS];
  logic signed [CounterW-1:0] cnt_mem  [NUM_SLOTS];

  // per-slot flags in flops, cleared by reset
  logic [NUM_SLOTS-1:0] slot_valid_q, slot_valid_d;
  logic [NUM_SLOTS-1:0] cnt_valid_q, cnt_valid_d;

  logic [1:0]       state_q, state_d;
  logic [CntW-1:0]  rd_idx_q, rd_idx_d;
  logic [SlotW-1:0] ev_idx_q;
  logic             rvalid_q;
  logic [TimeW-1:0] now_q;

  // read data registers
  task_entry_t                rd_task_q;
  logic signed [CounterW-1:0] rd_cnt_q;

  // the fired slot held back until we know whether another one follows
  logic               pend_valid_q, pend_valid_d;
  logic [SlotInW-1:0] pend_slot_q, pend_slot_d;

  // result registers
  logic               res_valid_q, res_valid_d;
  logic               res_fired_q, res_fired_d;
  logic [SlotInW-1:0] res_slot_q, res_slot_d;
  logic               res_last_q, res_last_d;

  // input side decode
  logic             accept;
  logic             slot_in_range;
  logic [SlotW-1:0] in_addr;
  logic             do_register, do_set_cnt, do_scan;

  // memory port controls
  logic                       rd_en;
  logic [SlotW-1:0]           rd_addr;
  logic                       task_we;
  logic [SlotW-1:0]           task_wa;
  task_entry_t                task_wd;
  logic                       cnt_we;
  logic [SlotW-1:0]           cnt_wa;
  logic signed [CounterW-1:0] cnt_wd;

  // evaluation of the slot whose entry was just read
  logic                       elapsed;
  logic signed [CounterW-1:0] cur_cnt;
  logic                       positive;
  logic                       pos_eff;
  logic                       fires;
  logic                       last_slot;

  assign accept        = start && !busy;
  assign slot_in_range = {{(CmpW-SlotInW){1'b0}}, slot_i} < CmpW'(NUM_SLOTS);
  assign in_addr       = SlotW'(slot_i);
  assign do_register   = accept && (mode_i == MODE_REGISTER) && slot_in_range;
  assign do_set_cnt    = accept && (mode_i == MODE_SET_COUNTER) && slot_in_range;
  assign do_scan       = accept && (mode_i == MODE_SCAN);

  // walk the table one slot a cycle
  assign rd_en   = (state_q == ST_SCAN) && (rd_idx_q != CntW'(NUM_SLOTS));
  assign rd_addr = rd_idx_q[SlotW-1:0];

  // firing rule; an unset counter reads as zero
  assign elapsed   = (now_q - rd_task_q.last_time) >= rd_task_q.interval;
  assign cur_cnt   = cnt_valid_q[ev_idx_q] ? rd_cnt_q : '0;
  assign positive  = !cur_cnt[CounterW-1] && (cur_cnt != '0);
  assign pos_eff   = rd_task_q.has_flag ? positive : 1'b1;
  assign fires     = rvalid_q && slot_valid_q[ev_idx_q] &&
                     (rd_task_q.or_mode ? (elapsed || pos_eff) : (elapsed && pos_eff));
  assign last_slot = rvalid_q && (ev_idx_q == SlotW'(NUM_SLOTS - 1));

  // write ports: register and counter items when idle, write-back of fired slots in a scan
  always_comb begin
    task_we = 1'b0;
    task_wa = in_addr;
    task_wd = '{interval: task_interval_i, last_time: now_ms_i,
                or_mode: or_mode_i, has_flag: has_flag_i};
    cnt_we  = 1'b0;
    cnt_wa  = in_addr;
    cnt_wd  = flag_value_i;
    if (do_register) begin
      task_we = 1'b1;
    end else if (fires) begin
      task_we           = 1'b1;
      task_wa           = ev_idx_q;
      task_wd           = rd_task_q;
      task_wd.last_time = now_q;
    end
    if (do_set_cnt) begin
      cnt_we = 1'b1;
    end else if (fires && rd_task_q.has_flag && positive) begin
      cnt_we = 1'b1;
      cnt_wa = ev_idx_q;
      cnt_wd = cur_cnt - CounterW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (task_we) begin
      task_mem[task_wa] <= task_wd;
    end
    if (rd_en) begin
      rd_task_q <= task_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (rd_en) begin
      rd_cnt_q <= cnt_mem[rd_addr];
    end
  end

  // scan sequencer and result generation
  always_comb begin
    state_d      = state_q;
    rd_idx_d     = rd_idx_q;
    slot_valid_d = slot_valid_q;
    cnt_valid_d  = cnt_valid_q;
    pend_valid_d = pend_valid_q;
    pend_slot_d  = pend_slot_q;
    res_valid_d  = 1'b0;
    res_fired_d  = 1'b0;
    res_slot_d   = '0;
    res_last_d   = 1'b0;

    if (do_register) begin
      slot_valid_d[in_addr] = 1'b1;
    end
    if (do_set_cnt) begin
      cnt_valid_d[in_addr] = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (do_scan) begin
          state_d      = ST_SCAN;
          rd_idx_d     = '0;
          pend_valid_d = 1'b0;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          rd_idx_d = rd_idx_q + CntW'(1);
        end
        // a newly fired slot releases the one held back, which is then not the last
        if (fires) begin
          if (pend_valid_q) begin
            res_valid_d = 1'b1;
            res_fired_d = 1'b1;
            res_slot_d  = pend_slot_q;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = SlotInW'(ev_idx_q);
        end
        if (last_slot) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        // final result: the held slot, or the empty marker when nothing fired
        res_valid_d  = 1'b1;
        res_fired_d  = pend_valid_q;
        res_slot_d   = pend_valid_q ? pend_slot_q : '0;
        res_last_d   = 1'b1;
        pend_valid_d = 1'b0;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rd_idx_q     <= '0;
      ev_idx_q     <= '0;
      rvalid_q     <= 1'b0;
      slot_valid_q <= '0;
      cnt_valid_q  <= '0;
      pend_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      rd_idx_q     <= rd_idx_d;
      ev_idx_q     <= rd_addr;
      rvalid_q     <= rd_en;
      slot_valid_q <= slot_valid_d;
      cnt_valid_q  <= cnt_valid_d;
      pend_valid_q <= pend_valid_d;
      res_valid_q  <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (do_scan) begin
      now_q <= now_ms_i;
    end
    pend_slot_q <= pend_slot_d;
    res_fired_q <= res_fired_d;
    res_slot_q  <= res_slot_d;
    res_last_q  <= res_last_d;
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign fired_o        = res_fired_q;
  assign fired_slot_o   = res_slot_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  // an empty result only ever closes a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !fired_o) |-> last_o)
    else $error("empty result without last marker");

  // the sequencer returns to idle exactly with the final result of a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> (result_valid_o && last_o))
    else $error("scan ended without final result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |-> !busy)
    else $error("final result while scan still running");

  // a scan item always starts the sequencer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (mode_i == MODE_SCAN)) |=> busy)
    else $error("scan item did not start the walk");

  // reads of the table happen only while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvalid_q |-> busy)
    else $error("table read outside a scan");
`endif

endmodule

[sim/periodic_task_dispatcher_checker.sv]
`timescale 1ns / 1ps
// result checker for the periodic task dispatcher: mirrors the task table and compares results
module periodic_task_dispatcher_checker
  import ptd_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic [ModeW-1:0]           mode_i,
  input  logic [SlotInW-1:0]         slot_i,
  input  logic [TimeW-1:0]           task_interval_i,
  input  logic                       or_mode_i,
  input  logic                       has_flag_i,
  input  logic signed [CounterW-1:0] flag_value_i,
  input  logic [TimeW-1:0]           now_ms_i,
  input  logic                       result_valid_i,
  input  logic                       fired_i,
  input  logic [SlotInW-1:0]         fired_slot_i,
  input  logic                       last_i,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);

  localparam int unsigned MaxResults = 16;
  localparam int unsigned MaxPrinted = 40;

  typedef struct packed {
    logic               fired;
    logic [SlotInW-1:0] slot;
    logic               last;
  } dispatch_t;

  logic                       valid_q   [NUM_SLOTS];
  task_entry_t                entry_q   [NUM_SLOTS];
  logic signed [CounterW-1:0] counter_q [NUM_SLOTS];
  dispatch_t                  due_tasks_q [$];
  int unsigned                fails;

  task automatic report_mismatch(input string what, input dispatch_t got,
                                 input dispatch_t want);
    fails++;
    if (fails <= MaxPrinted) begin
      $display({"mismatch at %0t: %s: got fired=%b slot=%0d last=%b,",
                " want fired=%b slot=%0d last=%b"},
               $time, what, got.fired, got.slot, got.last, want.fired, want.slot, want.last);
    end
  endtask

  // walk the valid slots in index order, update the mirror and queue the due tasks
  task automatic dispatch_scan(input logic [TimeW-1:0] now);
    logic [TimeW-1:0] since;
    logic             elapsed;
    logic             positive;
    int unsigned      hits;
    hits = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (valid_q[i] && hits < MaxResults) begin
        since    = now - entry_q[i].last_time;
        elapsed  = since >= entry_q[i].interval;
        positive = entry_q[i].has_flag ? (counter_q[i] > 0) : 1'b1;
        if (entry_q[i].or_mode ? (elapsed || positive) : (elapsed && positive)) begin
          entry_q[i].last_time = now;
          if (entry_q[i].has_flag && counter_q[i] > 0) counter_q[i] = counter_q[i] - 8'sd1;
          due_tasks_q.push_back('{fired: 1'b1, slot: i[SlotInW-1:0], last: 1'b0});
          hits++;
        end
      end
    end
    if (hits == 0) due_tasks_q.push_back('{fired: 1'b0, slot: '0, last: 1'b1});
    else due_tasks_q[due_tasks_q.size()-1].last = 1'b1;
  endtask

  task automatic apply_item();
    case (mode_i)
      MODE_REGISTER: begin
        if (slot_i < NUM_SLOTS) begin
          valid_q[slot_i] = 1'b1;
          entry_q[slot_i] = '{interval: task_interval_i, last_time: now_ms_i,
                              or_mode: or_mode_i, has_flag: has_flag_i};
        end
      end
      MODE_SET_COUNTER: begin
        if (slot_i < NUM_SLOTS) counter_q[slot_i] = flag_value_i;
      end
      MODE_SCAN: begin
        dispatch_scan(now_ms_i);
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    dispatch_t got;
    dispatch_t want;
    got = '{fired: fired_i, slot: fired_slot_i, last: last_i};
    if (due_tasks_q.size() == 0) begin
      report_mismatch("result with nothing outstanding", got, '0);
    end else begin
      want = due_tasks_q.pop_front();
      if (got.fired !== want.fired || got.slot !== want.slot || got.last !== want.last) begin
        report_mismatch("result differs", got, want);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        valid_q[i]   = 1'b0;
        counter_q[i] = '0;
      end
      due_tasks_q.delete();
      fails = 0;
    end else begin
      if (result_valid_i) check_result();
      if (start_i && !busy_i) apply_item();
    end
    fail_count_o = fails;
    pending_o    = due_tasks_q.size();
  end

endmodule

[sim/periodic_task_dispatcher_tb.sv]
`timescale 1ns / 1ps
// testbench top for the periodic task dispatcher: command stimulus, timeout and verdict
module periodic_task_dispatcher_tb;
  import ptd_pkg::*;

  localparam int unsigned NUM_SLOTS = NumSlotsDef;
  // mode code the block must ignore
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;
  // counted items per random phase, four phases
  localparam int unsigned ITEMS_PER_PHASE = 43;
  // scans and the gaps between items are short, so this is far beyond any good run
  localparam int unsigned CYCLE_LIMIT = 200000;
  // drain time after the last expected result
  localparam int unsigned TAIL_CYCLES = NUM_SLOTS + 6;

  // every input starts at a known value
  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       start           = 1'b0;
  logic [ModeW-1:0]           mode_i          = MODE_REGISTER;
  logic [SlotInW-1:0]         slot_i          = '0;
  logic [TimeW-1:0]           task_interval_i = '0;
  logic                       or_mode_i       = 1'b0;
  logic                       has_flag_i      = 1'b0;
  logic signed [CounterW-1:0] flag_value_i    = '0;
  logic [TimeW-1:0]           now_ms_i        = '0;
  logic                       busy;
  logic                       result_valid_o;
  logic                       fired_o;
  logic [SlotInW-1:0]         fired_slot_o;
  logic                       last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count;

  // chance in percent that the sender keeps idling after an item, drawn anew before each idle step
  int unsigned idle_pct = 0;
  // the dispatcher's notion of now, kept mostly increasing so that intervals matter
  logic [TimeW-1:0] now_q = 32'h0000_0100;

  periodic_task_dispatcher #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .task_interval_i(task_interval_i),
    .or_mode_i      (or_mode_i),
    .has_flag_i     (has_flag_i),
    .flag_value_i   (flag_value_i),
    .now_ms_i       (now_ms_i),
    .result_valid_o (result_valid_o),
    .fired_o        (fired_o),
    .fired_slot_o   (fired_slot_o),
    .last_o         (last_o)
  );

  periodic_task_dispatcher_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .mode_i         (mode_i),
    .slot_i         (slot_i),
    .task_interval_i(task_interval_i),
    .or_mode_i      (or_mode_i),
    .has_flag_i     (has_flag_i),
    .flag_value_i   (flag_value_i),
    .now_ms_i       (now_ms_i),
    .result_valid_i (result_valid_o),
    .fired_i        (fired_o),
    .fired_slot_i   (fired_slot_o),
    .last_i         (last_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  always #5 clk_i = ~clk_i;

  // present one item and hold it until the block takes it, then maybe idle a while
  task automatic send_cmd(input logic [ModeW-1:0] mode, input logic [SlotInW-1:0] slot,
                          input logic [TimeW-1:0] interval, input logic orm,
                          input logic hflag, input logic signed [CounterW-1:0] fval,
                          input logic [TimeW-1:0] now);
    start           <= 1'b1;
    mode_i          <= mode;
    slot_i          <= slot;
    task_interval_i <= interval;
    or_mode_i       <= orm;
    has_flag_i      <= hflag;
    flag_value_i    <= fval;
    now_ms_i        <= now;
    // busy is read as it was just before the edge, so this edge took the item if it was low
    do @(posedge clk_i); while (busy);
    // gaps of random length land on every cycle of a running scan
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // fields a mode does not use carry random junk, but set-counter items carry now_q as their time
  task automatic register_task(input logic [SlotInW-1:0] slot, input logic [TimeW-1:0] interval,
                               input logic orm, input logic hflag);
    send_cmd(MODE_REGISTER, slot, interval, orm, hflag, CounterW'($urandom), now_q);
  endtask

  task automatic set_counter(input logic [SlotInW-1:0] slot,
                             input logic signed [CounterW-1:0] fval);
    send_cmd(MODE_SET_COUNTER, slot, $urandom, 1'($urandom), 1'($urandom), fval, now_q);
  endtask

  task automatic scan_at(input logic [TimeW-1:0] now);
    now_q = now;
    send_cmd(MODE_SCAN, SlotInW'($urandom), $urandom, 1'($urandom), 1'($urandom),
             CounterW'($urandom), now_q);
  endtask

  // hard stop if the run hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_idle [4];
    int unsigned counted;
    int unsigned pick;
    int unsigned sel;
    logic [TimeW-1:0] interval;
    logic signed [CounterW-1:0] fval;

    // no idling, sender idle, receiver phase (results cannot be held off, so no idling), both
    phase_idle = '{0, 74, 0, 33};

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    scan_at(32'h0000_0100);                     // empty table: one not-fired result
    register_task(4'd0, 32'd0, 1'b0, 1'b0);     // zero interval, no flag: due on every scan
    register_task(4'd15, 32'hFFFF_FFFF, 1'b1, 1'b1); // or mode, counter still at reset zero
    scan_at(now_q + 1);                         // only slot 0
    set_counter(4'd15, 8'sd127);                // largest counter
    scan_at(now_q + 1);                         // slot 15 fires on its counter alone
    set_counter(4'd3, 8'sd1);                   // counter loaded on an unregistered slot
    register_task(4'd3, 32'd5, 1'b0, 1'b1);     // registering keeps that counter
    scan_at(now_q + 4);                         // slot 3 not yet elapsed
    scan_at(now_q + 5);                         // slot 3 fires, counter drops to zero
    scan_at(now_q + 10);                        // slot 3 elapsed but counter zero
    register_task(4'd7, 32'd2, 1'b0, 1'b1);
    set_counter(4'd7, -8'sd128);                // most negative counter never fires in and mode
    register_task(4'd8, 32'd3, 1'b1, 1'b1);
    set_counter(4'd8, -8'sd1);                  // or mode with negative counter: time only
    send_cmd(MODE_UNUSED, 4'd9, $urandom, 1'b1, 1'b1, 8'sd5, now_q); // ignored mode
    scan_at(now_q + 3);
    register_task(4'd0, 32'd100, 1'b0, 1'b0);   // re-register in place
    scan_at(32'hFFFF_FFF0);                     // jump close to the wrap point
    scan_at(32'h0000_0010);                     // elapsed time across the wrap
    set_counter(4'd15, 8'sd0);
    scan_at(now_q);                             // same time again, zero elapsed

    // random part: mostly register, counter and scan sequences over an advancing clock
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      counted  = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 8) begin
          // ignored mode, does not count
          send_cmd(MODE_UNUSED, SlotInW'($urandom), $urandom, 1'($urandom), 1'($urandom),
                   CounterW'($urandom), $urandom);
        end else begin
          counted++;
          if (pick < 50) begin
            sel = $urandom_range(9);
            if (sel == 0) scan_at($urandom);
            else if (sel == 1) scan_at(now_q + $urandom);
            else scan_at(now_q + $urandom_range(40));
          end else if (pick < 75) begin
            sel = $urandom_range(9);
            if (sel == 0) interval = '0;
            else if (sel == 1) interval = '1;
            else if (sel == 2) interval = $urandom;
            else interval = $urandom_range(60);
            register_task(SlotInW'($urandom_range(15)), interval, 1'($urandom), 1'($urandom));
          end else begin
            sel = $urandom_range(9);
            if (sel < 3) fval = CounterW'($urandom);
            else fval = CounterW'($signed($urandom_range(8)) - 2);
            set_counter(SlotInW'($urandom_range(15)), fval);
          end
        end
      end
    end

    start <= 1'b0;
    // the checker settles between edges, so read its counts on the falling edge
    do @(negedge clk_i); while (pending != 0);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[periodic_task_dispatcher.f]
hdl/ptd_pkg.sv
hdl/periodic_task_dispatcher.sv
sim/periodic_task_dispatcher_checker.sv
sim/periodic_task_dispatcher_tb.sv
